// File: rtl/core/lprm_pkg.sv
// lprm_pkg: shared types, constants and the sequencer control store for the
// longest-prefix rule match core. No dependencies.

package lprm_pkg;

  localparam int MAX_RULES_DEF = 16;
  localparam int ADDR_W        = 32;
  localparam int LEN_W         = 6;
  localparam int CNT_CFG_W     = 5;
  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // register index as seen in paddr[2]
  localparam logic REG_RULE_COUNT = 1'b0;

  typedef enum logic [1:0] {
    STEP_IDLE   = 2'd0,
    STEP_SETUP  = 2'd1,
    STEP_SCAN   = 2'd2,
    STEP_RESULT = 2'd3
  } step_t;

  typedef enum logic [1:0] {
    COND_NO_XFER  = 2'd0,
    COND_NO_SCAN  = 2'd1,
    COND_MORE     = 2'd2,
    COND_OUT_BUSY = 2'd3
  } cond_t;

  typedef struct packed {
    logic  in_rdy;
    logic  setup;
    logic  scan;
    logic  out_load;
    cond_t cond;
    step_t jmp;
    step_t nxt;
  } ctrl_t;

  // control store: when cond holds go to jmp, else to nxt
  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t w;
    w = '{in_rdy: 1'b0, setup: 1'b0, scan: 1'b0, out_load: 1'b0,
          cond: COND_NO_XFER, jmp: STEP_IDLE, nxt: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        w.in_rdy = 1'b1;
        w.cond   = COND_NO_XFER;
        w.jmp    = STEP_IDLE;
        w.nxt    = STEP_SETUP;
      end
      STEP_SETUP: begin
        w.setup = 1'b1;
        w.cond  = COND_NO_SCAN;
        w.jmp   = STEP_RESULT;
        w.nxt   = STEP_SCAN;
      end
      STEP_SCAN: begin
        w.scan = 1'b1;
        w.cond = COND_MORE;
        w.jmp  = STEP_SCAN;
        w.nxt  = STEP_RESULT;
      end
      STEP_RESULT: begin
        w.out_load = 1'b1;
        w.cond     = COND_OUT_BUSY;
        w.jmp      = STEP_RESULT;
        w.nxt      = STEP_IDLE;
      end
      default: begin
        w.cond = COND_NO_XFER;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/longest_prefix_rule_match_core.sv
// longest_prefix_rule_match_core: rule table, microcoded scan sequencer and
// output register. Depends on lprm_pkg.
//
// Usage: the input channel (in_*) carries one item per transfer. cmd write
// stores rule_address/rule_length into table slot; cmd lookup scans slots
// 0 .. min(rule_count, MAX_RULES)-1 and returns the longest matching prefix,
// lowest slot on a tie. Every item yields exactly one result transfer on the
// out_* channel (all zero for writes and for a lookup without a match).
// rule_count is set through the APB port at byte address 0.
// Timing: an item is taken only in the idle step. A write goes from the setup
// step straight to the result step, a lookup passes through one scan step per
// scanned slot between them, and the result step returns to idle for the next
// item. The scan reads one table entry per cycle through the single registered
// read port of the rule memory.
// A finished result sits in the output register; the core meanwhile takes
// the next item and stalls only when a second result is ready before the
// first is taken. Reset clears the sequencer, out_valid and rule_count; the
// table is not cleared and a slot must be written before a lookup scans it.

module longest_prefix_rule_match_core #(
  parameter int MAX_RULES = lprm_pkg::MAX_RULES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_cmd,
  input  logic [3:0]                        in_slot,
  input  logic [lprm_pkg::ADDR_W-1:0]       in_rule_address,
  input  logic [lprm_pkg::LEN_W-1:0]        in_rule_length,
  input  logic [lprm_pkg::ADDR_W-1:0]       in_lookup_address,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_matched,
  output logic [3:0]                        out_match_index,
  output logic [lprm_pkg::LEN_W-1:0]        out_match_length,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lprm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lprm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lprm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int IDX_W  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W  = $clog2(MAX_RULES + 1);
  localparam int WORD_W = lprm_pkg::ADDR_W + lprm_pkg::LEN_W;

  lprm_pkg::step_t step_r, step_nxt;
  lprm_pkg::ctrl_t cw;

  logic [lprm_pkg::CNT_CFG_W-1:0] rule_count_r;
  logic                           out_valid_r;

  // captured item
  logic                           cmd_r;
  logic [3:0]                     slot_r;
  logic [lprm_pkg::ADDR_W-1:0]    rule_addr_r;
  logic [lprm_pkg::LEN_W-1:0]     rule_len_r;
  logic [lprm_pkg::ADDR_W-1:0]    lookup_addr_r;

  // scan datapath
  logic [CNT_W-1:0]               ptr_r;
  logic [CNT_W-1:0]               ptr_inc;
  logic [CNT_W-1:0]               limit;
  logic [IDX_W-1:0]               rd_addr;
  logic [WORD_W-1:0]              rdata_r;
  logic                           best_found_r;
  logic [IDX_W-1:0]               best_idx_r;
  logic [lprm_pkg::LEN_W-1:0]     best_len_r;

  logic [lprm_pkg::LEN_W-1:0]     cand_len;
  logic [lprm_pkg::ADDR_W-1:0]    cand_pfx;
  logic [lprm_pkg::ADDR_W-1:0]    cand_mask;
  logic                           cand_hit;

  logic                           out_matched_r;
  logic [3:0]                     out_idx_r;
  logic [lprm_pkg::LEN_W-1:0]     out_len_r;

  logic                           in_xfer;
  logic                           cfg_wr;
  logic                           cond_true;
  logic                           out_busy;
  logic                           load_fire;
  logic                           mem_we;

  logic [WORD_W-1:0]              rule_mem [MAX_RULES];

  assign cw       = lprm_pkg::ucode_rom(step_r);
  assign in_ready = cw.in_rdy;
  assign in_xfer  = in_valid && cw.in_rdy;
  assign out_busy = out_valid_r && !out_ready;
  assign load_fire = cw.out_load && !out_busy;

  assign limit = (int'(rule_count_r) > MAX_RULES) ? CNT_W'(MAX_RULES)
                                                  : CNT_W'(rule_count_r);
  assign ptr_inc = ptr_r + CNT_W'(1);

  always_comb begin
    case (cw.cond)
      lprm_pkg::COND_NO_XFER:  cond_true = !in_valid;
      lprm_pkg::COND_NO_SCAN:  cond_true = (cmd_r == lprm_pkg::CMD_WRITE) ||
                                           (limit == '0);
      lprm_pkg::COND_MORE:     cond_true = (ptr_inc != limit);
      lprm_pkg::COND_OUT_BUSY: cond_true = out_busy;
      default:                 cond_true = 1'b0;
    endcase
    step_nxt = cond_true ? cw.jmp : cw.nxt;
  end

  // read address runs one slot ahead of the compare
  always_comb begin
    if (cw.setup || int'(ptr_inc) >= MAX_RULES) begin
      rd_addr = '0;
    end else begin
      rd_addr = ptr_inc[IDX_W-1:0];
    end
  end

  assign mem_we = cw.setup && (cmd_r == lprm_pkg::CMD_WRITE) && (int'(slot_r) < MAX_RULES);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rule_mem[IDX_W'(slot_r)] <= {rule_len_r, rule_addr_r};
    end
    rdata_r <= rule_mem[rd_addr];
  end

  assign cand_len  = rdata_r[lprm_pkg::ADDR_W +: lprm_pkg::LEN_W];
  assign cand_pfx  = rdata_r[lprm_pkg::ADDR_W-1:0];
  assign cand_mask = ~({lprm_pkg::ADDR_W{1'b1}} >> cand_len);
  assign cand_hit  = (cand_len > best_len_r) &&
                     (((lookup_addr_r ^ cand_pfx) & cand_mask) == '0);

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    prdata = '0;
    if (paddr[2] == lprm_pkg::REG_RULE_COUNT) begin
      prdata = lprm_pkg::APB_DATA_W'(rule_count_r);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= lprm_pkg::STEP_IDLE;
      out_valid_r  <= 1'b0;
      rule_count_r <= '0;
    end else begin
      step_r <= step_nxt;
      if (load_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr && paddr[2] == lprm_pkg::REG_RULE_COUNT) begin
        rule_count_r <= pwdata[lprm_pkg::CNT_CFG_W-1:0];
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r         <= in_cmd;
      slot_r        <= in_slot;
      rule_addr_r   <= in_rule_address;
      rule_len_r    <= (in_rule_length > lprm_pkg::MAX_LEN) ? lprm_pkg::MAX_LEN
                                                           : in_rule_length;
      lookup_addr_r <= in_lookup_address;
    end
    if (cw.setup) begin
      ptr_r        <= '0;
      best_found_r <= 1'b0;
      best_idx_r   <= '0;
      best_len_r   <= '0;
    end else if (cw.scan) begin
      ptr_r <= ptr_inc;
      if (cand_hit) begin
        best_found_r <= 1'b1;
        best_idx_r   <= ptr_r[IDX_W-1:0];
        best_len_r   <= cand_len;
      end
    end
    if (load_fire) begin
      out_matched_r <= best_found_r;
      out_idx_r     <= 4'(best_idx_r);
      out_len_r     <= best_len_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_matched      = out_matched_r;
  assign out_match_index  = out_idx_r;
  assign out_match_length = out_len_r;

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == lprm_pkg::STEP_SCAN) |-> (ptr_r < limit))
    else $error("scan pointer beyond rule count");

  a_xfer_to_setup: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (step_r == lprm_pkg::STEP_SETUP))
    else $error("accepted item did not start setup");

  a_match_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_matched_r) |->
      (out_len_r != '0 && out_len_r <= lprm_pkg::MAX_LEN))
    else $error("match reported with bad length");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == lprm_pkg::STEP_RESULT && !out_valid_r) |=> out_valid_r)
    else $error("result step did not raise out_valid");

endmodule

// File: verif/tb_longest_prefix_rule_match_core.sv
// tb_longest_prefix_rule_match_core: self-checking testbench for the prefix rule table,
// with a directed table followed by random rule writes and lookups over several rule counts.
// Depends on lprm_pkg and longest_prefix_rule_match_core.

module tb_longest_prefix_rule_match_core;

  localparam int ADDR_W     = lprm_pkg::ADDR_W;
  localparam int LEN_W      = lprm_pkg::LEN_W;
  localparam int CNT_CFG_W  = lprm_pkg::CNT_CFG_W;
  localparam int APB_ADDR_W = lprm_pkg::APB_ADDR_W;
  localparam int APB_DATA_W = lprm_pkg::APB_DATA_W;
  localparam logic [LEN_W-1:0] MAX_LEN = lprm_pkg::MAX_LEN;
  localparam logic CMD_WRITE  = lprm_pkg::CMD_WRITE;
  localparam logic CMD_LOOKUP = lprm_pkg::CMD_LOOKUP;

  localparam int TABLE_DEPTH = lprm_pkg::MAX_RULES_DEF;
  localparam int PHASE_ITEMS = 83;
  localparam int HOLD_CYCLES = 300;
  localparam logic [ADDR_W-1:0] ALL_ONES = '1;
  localparam logic [APB_ADDR_W-1:0] RULE_COUNT_ADDR = {lprm_pkg::REG_RULE_COUNT, 2'b00};

  typedef struct packed {
    logic              cmd;
    logic [3:0]        slot;
    logic [ADDR_W-1:0] rule_address;
    logic [LEN_W-1:0]  rule_length;
    logic [ADDR_W-1:0] lookup_address;
  } rule_item_t;

  typedef struct packed {
    logic             matched;
    logic [3:0]       index;
    logic [LEN_W-1:0] length;
  } match_t;

  localparam match_t NO_MATCH = '0;

  typedef enum logic {ROW_ITEM, ROW_COUNT} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CNT_CFG_W-1:0] count;
    rule_item_t           item;
    logic                 fixed;
    match_t               want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready, in_cmd;
  logic [3:0] in_slot;
  logic [ADDR_W-1:0] in_rule_address, in_lookup_address;
  logic [LEN_W-1:0] in_rule_length;
  logic out_valid, out_ready, out_matched;
  logic [3:0] out_match_index;
  logic [LEN_W-1:0] out_match_length;
  logic psel, penable, pwrite, pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata, prdata;

  // typed expectation that travels with the payload of a directed row
  logic   fixed_result;
  match_t fixed_want;

  // predictor copy of the table and of rule_count
  logic [ADDR_W-1:0]    rule_prefix [TABLE_DEPTH];
  logic [LEN_W-1:0]     rule_len [TABLE_DEPTH];
  logic [CNT_CFG_W-1:0] scan_count;

  match_t pending_matches [$];
  int mismatches;
  int burst_left;
  int hold_requests;
  int hold_served;

  plan_row_t directed_plan [24] = '{
    '{ROW_ITEM, 5'd0, '{CMD_LOOKUP, 4'hF, ALL_ONES, 6'h3F, ALL_ONES}, 1'b1, NO_MATCH},
    '{ROW_ITEM, 5'd0, '{CMD_WRITE, 4'd0, 32'h0A00_0000, 6'd8, ALL_ONES}, 1'b1, NO_MATCH},
    '{ROW_ITEM, 5'd0, '{CMD_WRITE, 4'd1, 32'h0A01_0000, 6'd16, 32'h0}, 1'b1, NO_MATCH},
    '{ROW_ITEM, 5'd0, '{CMD_WRITE, 4'd2, 32'h0A01_0100, 6'd24, ALL_ONES}, 1'b1, NO_MATCH},
    '{ROW_ITEM, 5'd0, '{CMD_WRITE, 4'd3, 32'h0A01_0101, 6'd32, 32'h0}, 1'b1, NO_MATCH},
    '{ROW_ITEM, 5'd0, '{CMD_WRITE, 4'd4, 32'h0000_0000, 6'd0, ALL_ONES}, 1'b1, NO_MATCH},
    '{ROW_ITEM, 5'd0, '{CMD_WRITE, 4'd5, ALL_ONES, 6'd63, 32'h0}, 1'b1, NO_MATCH},
    '{ROW_ITEM, 5'd0, '{CMD_WRITE, 4'd6, 32'h0A00_0000, 6'd8, ALL_ONES}, 1'b1, NO_MATCH},
    '{ROW_ITEM, 5'd0, '{CMD_WRITE, 4'd7, 32'hC0A8_0000, 6'd33, 32'h0}, 1'b1, NO_MATCH},
    '{ROW_ITEM, 5'd0, '{CMD_WRITE, 4'd8, 32'h8000_0000, 6'd1, ALL_ONES}, 1'b1, NO_MATCH},
    '{ROW_ITEM, 5'd0, '{CMD_WRITE, 4'd9, 32'h0000_0000, 6'd1, 32'h0}, 1'b1, NO_MATCH},
    '{ROW_ITEM, 5'd0, '{CMD_WRITE, 4'd10, 32'hC0A8_0000, 6'd16, ALL_ONES}, 1'b1, NO_MATCH},
    '{ROW_ITEM, 5'd0, '{CMD_WRITE, 4'd11, 32'hAC10_0000, 6'd12, 32'h0}, 1'b1, NO_MATCH},
    '{ROW_ITEM, 5'd0, '{CMD_WRITE, 4'd12, ALL_ONES, 6'd32, ALL_ONES}, 1'b1, NO_MATCH},
    '{ROW_ITEM, 5'd0, '{CMD_WRITE, 4'd13, 32'h0A01_0101, 6'd31, 32'h0}, 1'b1, NO_MATCH},
    '{ROW_ITEM, 5'd0, '{CMD_WRITE, 4'd14, 32'hC0A8_0100, 6'd24, ALL_ONES}, 1'b1, NO_MATCH},
    '{ROW_ITEM, 5'd0, '{CMD_WRITE, 4'd15, 32'h1234_5678, 6'd32, 32'h0}, 1'b1, NO_MATCH},
    // count above the table size scans all slots
    '{ROW_COUNT, 5'd31, '0, 1'b0, NO_MATCH},
    '{ROW_ITEM, 5'd0, '{CMD_LOOKUP, 4'hF, ALL_ONES, 6'h3F, 32'h0A01_0101}, 1'b0, NO_MATCH},
    '{ROW_ITEM, 5'd0, '{CMD_LOOKUP, 4'h0, 32'h0, 6'h00, 32'h0A01_02FF}, 1'b0, NO_MATCH},
    '{ROW_ITEM, 5'd0, '{CMD_LOOKUP, 4'hF, ALL_ONES, 6'h3F, 32'h0AFF_FFFF}, 1'b0, NO_MATCH},
    '{ROW_ITEM, 5'd0, '{CMD_LOOKUP, 4'h0, 32'h0, 6'h00, ALL_ONES}, 1'b0, NO_MATCH},
    '{ROW_ITEM, 5'd0, '{CMD_LOOKUP, 4'hF, ALL_ONES, 6'h3F, 32'hC0A8_0000}, 1'b0, NO_MATCH},
    '{ROW_ITEM, 5'd0, '{CMD_LOOKUP, 4'h0, 32'h0, 6'h00, 32'h0000_0000}, 1'b0, NO_MATCH}
  };

  longest_prefix_rule_match_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_slot           (in_slot),
    .in_rule_address   (in_rule_address),
    .in_rule_length    (in_rule_length),
    .in_lookup_address (in_lookup_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_matched       (out_matched),
    .out_match_index   (out_match_index),
    .out_match_length  (out_match_length),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #5 clk = ~clk;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    if (len == 0) return '0;
    return ALL_ONES << (ADDR_W - len);
  endfunction

  // updates the table copy on a rule write, scans it on a lookup
  function automatic match_t resolve_item(input rule_item_t it);
    match_t best;
    int limit;
    best = NO_MATCH;
    if (it.cmd == CMD_WRITE) begin
      rule_prefix[it.slot] = it.rule_address;
      rule_len[it.slot] = (it.rule_length > MAX_LEN) ? MAX_LEN : it.rule_length;
      return best;
    end
    limit = (scan_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(scan_count);
    for (int i = 0; i < limit; i++) begin
      if (rule_len[i] > best.length &&
          ((it.lookup_address ^ rule_prefix[i]) & prefix_mask(rule_len[i])) == '0) begin
        best.matched = 1'b1;
        best.index   = 4'(i);
        best.length  = rule_len[i];
      end
    end
    return best;
  endfunction

  function automatic logic [ADDR_W-1:0] pooled_address();
    case ($urandom_range(0, 3))
      0: return 32'h0A00_0000 | ($urandom() & 32'h00FF_FFFF);
      1: return 32'hC0A8_0000 | ($urandom() & 32'h0000_FFFF);
      2: return 32'hAC10_0000 | ($urandom() & 32'h000F_FFFF);
      default: return $urandom();
    endcase
  endfunction

  function automatic rule_item_t random_write_item();
    rule_item_t it;
    int src;
    it.cmd = CMD_WRITE;
    it.slot = 4'($urandom_range(0, TABLE_DEPTH - 1));
    it.lookup_address = $urandom();
    it.rule_address = pooled_address();
    case ($urandom_range(0, 9))
      0: it.rule_length = '0;
      1: it.rule_length = LEN_W'($urandom_range(33, 63));
      2, 3: it.rule_length = LEN_W'(8 * $urandom_range(1, 4));
      default: it.rule_length = LEN_W'($urandom_range(1, 32));
    endcase
    // copy of another slot makes ties
    if ($urandom_range(0, 7) == 0) begin
      src = $urandom_range(0, TABLE_DEPTH - 1);
      it.rule_address = rule_prefix[src];
      it.rule_length = rule_len[src];
    end
    return it;
  endfunction

  function automatic rule_item_t random_lookup_item();
    rule_item_t it;
    int src;
    it.cmd = CMD_LOOKUP;
    it.slot = 4'($urandom_range(0, 15));
    it.rule_address = $urandom();
    it.rule_length = LEN_W'($urandom_range(0, 63));
    src = $urandom_range(0, TABLE_DEPTH - 1);
    case ($urandom_range(0, 9))
      0, 1: it.lookup_address = $urandom();
      2: it.lookup_address = pooled_address();
      // inside some stored prefix, random below it
      default: it.lookup_address = rule_prefix[src] ^ ($urandom() & ~prefix_mask(rule_len[src]));
    endcase
    return it;
  endfunction

  task automatic note_mismatch(input string what, input match_t want, input match_t got);
    string exp_txt;
    string got_txt;
    mismatches++;
    if (mismatches <= 10) begin
      exp_txt = $sformatf("matched=%0d index=%0d length=%0d",
                          want.matched, want.index, want.length);
      got_txt = $sformatf("matched=%0d index=%0d length=%0d",
                          got.matched, got.index, got.length);
      $display("%0t: %s: expected %s, got %s", $time, what, exp_txt, got_txt);
    end
  endtask

  // offers one item in the current burst and returns at the negedge after its transfer
  task automatic offer_item(input rule_item_t it, input logic fixed, input match_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid          <= 1'b1;
    in_cmd            <= it.cmd;
    in_slot           <= it.slot;
    in_rule_address   <= it.rule_address;
    in_rule_length    <= it.rule_length;
    in_lookup_address <= it.lookup_address;
    fixed_result      <= fixed;
    fixed_want        <= want;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // only written with nothing in flight
  task automatic set_rule_count(input logic [CNT_CFG_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= RULE_COUNT_ADDR;
    pwdata  <= APB_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    scan_count = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // transfer bookkeeping on both channels
  always @(posedge clk) begin
    rule_item_t it;
    match_t want;
    match_t got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        it = '{in_cmd, in_slot, in_rule_address, in_rule_length, in_lookup_address};
        want = resolve_item(it);
        if (fixed_result) want = fixed_want;
        pending_matches.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = '{out_matched, out_match_index, out_match_length};
        if (pending_matches.size() == 0) begin
          note_mismatch("unexpected result", NO_MATCH, got);
        end else begin
          want = pending_matches.pop_front();
          if (got.matched !== want.matched || got.index !== want.index ||
              got.length !== want.length)
            note_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  // receiver: stall pattern changes every span, plus requested long hold-offs
  initial begin
    int mode;
    int span;
    int hold;
    mode = 0;
    span = 0;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (hold_requests != hold_served) begin
        hold_served++;
        hold = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(32, 256);
        end
        span--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (span % 4 == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    #3_000_000;
    $display("longest_prefix_rule_match_core regression: fail");
    $finish;
  end

  initial begin
    int counts [10];
    logic [CNT_CFG_W-1:0] count;
    counts = '{16, 0, 1, 31, 17, 8, -1, 16, 2, -1};
    mismatches = 0;
    burst_left = 0;
    hold_requests = 0;
    hold_served = 0;
    scan_count = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      rule_prefix[i] = '0;
      rule_len[i] = '0;
    end
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_cmd            <= CMD_WRITE;
    in_slot           <= '0;
    in_rule_address   <= '0;
    in_rule_length    <= '0;
    in_lookup_address <= '0;
    fixed_result      <= 1'b0;
    fixed_want        <= NO_MATCH;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_plan[r]) begin
      if (directed_plan[r].kind == ROW_COUNT)
        set_rule_count(directed_plan[r].count);
      else
        offer_item(directed_plan[r].item, directed_plan[r].fixed, directed_plan[r].want);
    end

    foreach (counts[p]) begin
      count = (counts[p] < 0) ? CNT_CFG_W'($urandom_range(0, 31)) : CNT_CFG_W'(counts[p]);
      set_rule_count(count);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off while the sender keeps offering
        if (p == 0 && n == 20) hold_requests++;
        if ($urandom_range(0, 3) == 0 || count == 0)
          offer_item(random_write_item(), 1'b0, NO_MATCH);
        else
          offer_item(random_lookup_item(), 1'b0, NO_MATCH);
      end
    end

    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (mismatches == 0 && pending_matches.size() == 0)
      $display("longest_prefix_rule_match_core regression: pass");
    else
      $display("longest_prefix_rule_match_core regression: fail");
    $finish;
  end

endmodule

// File: longest_prefix_rule_match_core.f
rtl/core/lprm_pkg.sv
rtl/core/longest_prefix_rule_match_core.sv
verif/tb_longest_prefix_rule_match_core.sv
